// ===== hdl/sfof_pkg.sv =====
package sfof_pkg;

  // Fixed field widths of the stream
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned UCOUNT_W = 7;
  localparam logic [UCOUNT_W-1:0] UCOUNT_MAX = 7'd127;

  // One result word
  typedef struct packed {
    logic signed [VALUE_W-1:0]  value_out;
    logic                       kept;
    logic        [UCOUNT_W-1:0] distinct_count;
    logic                       set_done;
    logic                       overflow;
  } result_t;

endpackage

// ===== hdl/sfof_ram.sv =====
module sfof_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/sfof_out_reg.sv =====
module sfof_out_reg
  import sfof_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t data_i,
  output logic    can_load_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t data_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  // Slot is free when empty or being drained this cycle
  assign can_load_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_i) begin
      valid_d = 1'b0;
    end
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== hdl/stream_first_occurrence_filter_top.sv =====
// Channel  Handshake                Word
// -------  -----------------------  -----------------------------------------------
// in       in_valid_i / in_ready_o  value_i, last_i
// out      out_valid_o/out_ready_i  value_out_o, kept_o, distinct_count_o,
//                                   set_done_o, overflow_o
//
// One word at a time: accept, then a scan that reads one table entry per
// cycle from the table RAM (one write port, one read port), ending early
// on a hit, then the decide cycle.
// The result sits in an output register, so the next word is taken while it
// waits; the decide cycle holds only if that register is still occupied.
// Reset clears count, overflow flag and control; table contents need none.
module stream_first_occurrence_filter_top
  import sfof_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [VALUE_W-1:0]  value_i,
  input  logic                       last_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [VALUE_W-1:0]  value_out_o,
  output logic                       kept_o,
  output logic        [UCOUNT_W-1:0] distinct_count_o,
  output logic                       set_done_o,
  output logic                       overflow_o
);

  localparam int unsigned AddrW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_ITEMS + 1);
  localparam int unsigned ExtW  = CntW + UCOUNT_W;
  localparam logic [CntW-1:0] CntFull = CntW'(MAX_ITEMS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]               state_q, state_d;
  logic [VALUE_W-1:0]       val_q, val_d;
  logic                     last_q, last_d;
  logic [CntW-1:0]          rd_idx_q, rd_idx_d;
  logic                     cmp_v_q, cmp_v_d;
  logic                     hit_q, hit_d;
  logic [CntW-1:0]          count_q, count_d;
  logic                     ovf_q, ovf_d;

  logic                     in_acc;
  logic                     issue, match;
  logic [VALUE_W-1:0]       rdata;
  logic                     ram_we;
  logic                     store, ovf_new, emit;
  logic [CntW-1:0]          count_new;
  logic [ExtW-1:0]          count_ext;
  logic                     out_load, out_can_load;
  result_t                  res, out_data;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // Scan: issue a read per cycle, compare the word returned by the previous read
  assign issue = (state_q == S_SCAN) && (rd_idx_q < count_q);
  assign match = (state_q == S_SCAN) && cmp_v_q && (rdata == val_q);

  // Decide: append on a miss while room remains
  assign store     = !hit_q && (count_q < CntFull);
  assign ovf_new   = ovf_q || (!hit_q && !store);
  assign count_new = count_q + CntW'(store);
  assign emit      = store || last_q;
  assign count_ext = ExtW'(count_new);

  // Table writes only happen in the decide cycle, never during a scan
  assign ram_we   = (state_q == S_DONE) && store && (!emit || out_can_load);
  assign out_load = (state_q == S_DONE) && emit && out_can_load;

  always_comb begin
    res.value_out      = store ? val_q : '0;
    res.kept           = store;
    res.distinct_count = (count_ext > ExtW'(UCOUNT_MAX)) ? UCOUNT_MAX
                                                         : count_ext[UCOUNT_W-1:0];
    res.set_done       = last_q;
    res.overflow       = ovf_new;
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    val_d    = val_q;
    last_d   = last_q;
    rd_idx_d = rd_idx_q;
    cmp_v_d  = cmp_v_q;
    hit_d    = hit_q;
    count_d  = count_q;
    ovf_d    = ovf_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          val_d    = value_i;
          last_d   = last_i;
          rd_idx_d = '0;
          cmp_v_d  = 1'b0;
          hit_d    = 1'b0;
          state_d  = S_SCAN;
        end
      end
      S_SCAN: begin
        cmp_v_d = issue;
        if (issue) begin
          rd_idx_d = rd_idx_q + CntW'(1);
        end
        if (match) begin
          hit_d   = 1'b1;
          state_d = S_DONE;
        end else if (!issue && !cmp_v_q) begin
          state_d = S_DONE;
        end else if (!issue) begin
          // last comparison just missed
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!emit || out_can_load) begin
          state_d = S_IDLE;
          if (last_q) begin
            count_d = '0;
            ovf_d   = 1'b0;
          end else begin
            count_d = count_new;
            ovf_d   = ovf_new;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cmp_v_q  <= 1'b0;
      hit_q    <= 1'b0;
      count_q  <= '0;
      ovf_q    <= 1'b0;
      rd_idx_q <= '0;
    end else begin
      state_q  <= state_d;
      cmp_v_q  <= cmp_v_d;
      hit_q    <= hit_d;
      count_q  <= count_d;
      ovf_q    <= ovf_d;
      rd_idx_q <= rd_idx_d;
    end
  end

  // Word under test, no reset needed
  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    last_q <= last_d;
  end

  sfof_ram #(
    .Depth(MAX_ITEMS),
    .Width(VALUE_W)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(count_q[AddrW-1:0]),
    .wdata_i(val_q),
    .re_i   (issue),
    .raddr_i(rd_idx_q[AddrW-1:0]),
    .rdata_o(rdata)
  );

  sfof_out_reg u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (out_load),
    .data_i    (res),
    .can_load_o(out_can_load),
    .valid_o   (out_valid_o),
    .ready_i   (out_ready_i),
    .data_o    (out_data)
  );

  assign value_out_o      = out_data.value_out;
  assign kept_o           = out_data.kept;
  assign distinct_count_o = out_data.distinct_count;
  assign set_done_o       = out_data.set_done;
  assign overflow_o       = out_data.overflow;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("stored count beyond table depth");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && issue))
    else $error("table write during scan");

  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_SCAN))
    else $error("accepted word did not start a scan");

  a_kept_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kept_o) |-> (distinct_count_o != '0))
    else $error("kept word reported with zero count");
`endif

endmodule

// ===== sim/stream_first_occurrence_filter_top_tb.sv =====
`timescale 1ns / 100ps

module stream_first_occurrence_filter_top_tb;
  import sfof_pkg::*;

  localparam int unsigned TABLE_DEPTH    = 64;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          SETTLE_CYCLES  = TABLE_DEPTH + 8;
  localparam int          MAX_REPORTS    = 50;
  localparam int          PHASE_WORDS    = 250;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic signed [VALUE_W-1:0]  value_i = '0;
  logic                       last_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic signed [VALUE_W-1:0]  value_out_o;
  logic                       kept_o;
  logic        [UCOUNT_W-1:0] distinct_count_o;
  logic                       set_done_o;
  logic                       overflow_o;

  // Predictor state: values seen in the current set, fill level, sticky overflow
  logic [VALUE_W-1:0] seen_vals [TABLE_DEPTH];
  int unsigned        seen_count = 0;
  bit                 set_overflow = 1'b0;
  result_t            pending_results [$];

  int  err_cnt = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_ready_low = 1'b0;
  int  quiet_cycles = 0;
  event hold_start;

  stream_first_occurrence_filter_top #(
    .MAX_ITEMS(TABLE_DEPTH)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .value_i         (value_i),
    .last_i          (last_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .value_out_o     (value_out_o),
    .kept_o          (kept_o),
    .distinct_count_o(distinct_count_o),
    .set_done_o      (set_done_o),
    .overflow_o      (overflow_o)
  );

  // 2 ns clock
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  task automatic report_mismatch(input string msg);
    if (err_cnt < MAX_REPORTS) $display("mismatch: %s", msg);
    err_cnt++;
  endtask

  // Dedup predictor: updates the table and queues the result word, if any
  task automatic dedup_predict(input logic [VALUE_W-1:0] v, input logic is_last);
    bit      hit;
    bit      stored;
    result_t res;
    hit = 1'b0;
    stored = 1'b0;
    for (int i = 0; i < seen_count; i++) begin
      if (seen_vals[i] == v) hit = 1'b1;
    end
    if (!hit) begin
      if (seen_count < TABLE_DEPTH) begin
        seen_vals[seen_count] = v;
        seen_count++;
        stored = 1'b1;
      end else begin
        set_overflow = 1'b1;
      end
    end
    if (stored || is_last) begin
      res.value_out      = stored ? v : '0;
      res.kept           = stored;
      res.distinct_count = (seen_count > UCOUNT_MAX) ? UCOUNT_MAX : UCOUNT_W'(seen_count);
      res.set_done       = is_last;
      res.overflow       = set_overflow;
      pending_results.push_back(res);
    end
    if (is_last) begin
      seen_count = 0;
      set_overflow = 1'b0;
    end
  endtask

  // Send one word; called at a rising edge, returns at the edge that took it
  task automatic send_word(input logic [VALUE_W-1:0] v, input logic is_last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    last_i     <= is_last;
    do @(posedge clk_i); while (!in_ready_o);
    dedup_predict(v, is_last);
  endtask

  // Stop offering words until every pending result has been taken
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return VALUE_W'($urandom_range(0, 3));
      default: return $urandom();
    endcase
  endfunction

  // Receiver: random stalls, or ready held low during a hold-off
  always @(posedge clk_i) begin
    out_ready_i <= !hold_ready_low && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Long receiver hold-off, counted here
  initial begin
    forever begin
      @(hold_start);
      hold_ready_low <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_ready_low <= 1'b0;
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    result_t exp_w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected word value_out=%h", value_out_o));
      end else begin
        exp_w = pending_results.pop_front();
        if (value_out_o !== exp_w.value_out)
          report_mismatch($sformatf("value_out %h, want %h", value_out_o, exp_w.value_out));
        if (kept_o !== exp_w.kept)
          report_mismatch($sformatf("kept %b, want %b", kept_o, exp_w.kept));
        if (distinct_count_o !== exp_w.distinct_count)
          report_mismatch($sformatf("distinct_count %0d, want %0d",
                                    distinct_count_o, exp_w.distinct_count));
        if (set_done_o !== exp_w.set_done)
          report_mismatch($sformatf("set_done %b, want %b", set_done_o, exp_w.set_done));
        if (overflow_o !== exp_w.overflow)
          report_mismatch($sformatf("overflow %b, want %b", overflow_o, exp_w.overflow));
      end
    end
  end

  // Watchdog: ends the run if neither channel moves a word for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Extremes of the value field, repeats, and a set ending on a repeat
  task automatic test_extremes();
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h7fff_ffff, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hffff_ffff, 1'b0);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h0000_0001, 1'b0);
    send_word(32'hffff_ffff, 1'b1);
  endtask

  // One-word sets, and a set whose last word is new
  task automatic test_short_sets();
    send_word(32'h0000_0005, 1'b1);
    send_word(32'h8000_0000, 1'b1);
    send_word(32'h5555_aaaa, 1'b0);
    send_word(32'h5555_aaaa, 1'b0);
    send_word(32'haaaa_5555, 1'b1);
  endtask

  // Fill the table, then offer more new values: dropped, flag stays till set end
  task automatic test_table_full();
    logic [VALUE_W-1:0] base;
    base = $urandom();
    for (int i = 0; i < TABLE_DEPTH; i++) send_word(base + i, 1'b0);
    send_word(base + TABLE_DEPTH, 1'b0);
    send_word(base, 1'b0);
    send_word(base + TABLE_DEPTH + 1, 1'b1);
    // flag and count must start clean on the next set
    send_word(base + TABLE_DEPTH, 1'b0);
    send_word(base, 1'b1);
  endtask

  // Receiver holds off while words keep coming, so the input stalls
  task automatic test_output_backpressure();
    logic [VALUE_W-1:0] base;
    base = $urandom();
    -> hold_start;
    for (int i = 0; i < 12; i++) send_word(base + i, i == 11);
    drain_results();
  endtask

  // Sender pauses mid-set until all results are out, then finishes the set
  task automatic test_sender_pause();
    send_word(32'h0000_0010, 1'b0);
    send_word(32'h0000_0011, 1'b0);
    send_word(32'h0000_0010, 1'b0);
    drain_results();
    send_word(32'h0000_0011, 1'b0);
    send_word(32'h0000_0012, 1'b1);
  endtask

  // Random sets: mostly short with small pools (many repeats), some long
  // walks over pools of 60 to 80 values, which can exceed the table and overflow
  task automatic send_random_set(output int n);
    logic [VALUE_W-1:0] pool [128];
    logic [VALUE_W-1:0] base;
    logic [VALUE_W-1:0] v;
    int                 npool;
    bit                 walk;
    walk = ($urandom_range(0, 14) == 0);
    if (walk) begin
      n = $urandom_range(66, 90);
      npool = $urandom_range(60, 80);
      base = $urandom();
      for (int i = 0; i < npool; i++) pool[i] = base + i;
    end else begin
      n = $urandom_range(1, 20);
      npool = $urandom_range(1, 12);
      for (int i = 0; i < npool; i++) pool[i] = pick_value();
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 8)
        v = walk ? pool[i % npool] : pool[$urandom_range(0, npool - 1)];
      else
        v = $urandom();
      send_word(v, i == n - 1);
    end
  endtask

  task automatic test_random(input int send_pct, input int recv_pct);
    int sent;
    int n;
    sent = 0;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    while (sent < PHASE_WORDS) begin
      send_random_set(n);
      sent += n;
    end
    drain_results();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_short_sets();
    test_table_full();
    drain_results();
    test_output_backpressure();
    test_sender_pause();
    drain_results();

    test_random(0, 0);
    test_random(57, 0);
    test_random(0, 57);
    test_random(6, 6);

    // let any word still in the scan come out before the verdict
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
